>>> src/aftp_pkg.sv
// ---------------------------------------------------------------------------
// aftp_pkg
// Shared constants and types for the three-point affine solver.
// ---------------------------------------------------------------------------
package aftp_pkg;

   localparam int QW = 32;
   localparam logic [QW-1:0] SAT_MAX = 32'h7FFF_FFFF;
   localparam logic [QW-1:0] SAT_MIN = 32'h8000_0000;

   typedef struct packed {
      logic singular;
      logic neg;
      logic ovf;
   } aftp_flags_type;

endpackage

>>> src/aftp_ifs.sv
// ---------------------------------------------------------------------------
// aftp_ifs
// Valid/ready channels for point-pair requests and coefficient responses.
// ---------------------------------------------------------------------------
interface aftp_req_if #(parameter int COORD_BITS = 16) ();
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] src_ax, src_ay, src_bx, src_by, src_cx, src_cy;
   logic signed [COORD_BITS-1:0] dst_ax, dst_ay, dst_bx, dst_by, dst_cx, dst_cy;

   modport source (output valid, src_ax, src_ay, src_bx, src_by, src_cx, src_cy,
                   dst_ax, dst_ay, dst_bx, dst_by, dst_cx, dst_cy, input ready);
   modport sink   (input valid, src_ax, src_ay, src_bx, src_by, src_cx, src_cy,
                   dst_ax, dst_ay, dst_bx, dst_by, dst_cx, dst_cy, output ready);
endinterface

interface aftp_rsp_if ();
   logic                               valid;
   logic                               ready;
   logic signed [aftp_pkg::QW-1:0]     coef_xx, coef_xy, coef_yx, coef_yy;
   logic signed [aftp_pkg::QW-1:0]     shift_x, shift_y;
   logic                               singular;

   modport source (output valid, coef_xx, coef_xy, coef_yx, coef_yy, shift_x, shift_y,
                   singular, input ready);
   modport sink   (input valid, coef_xx, coef_xy, coef_yx, coef_yy, shift_x, shift_y,
                   singular, output ready);
endinterface

>>> src/aftp_setup.sv
// ---------------------------------------------------------------------------
// aftp_setup
// Cofactors, determinant, numerators and divider operand preparation.
// ---------------------------------------------------------------------------
module aftp_setup #(
   parameter int COORD_BITS = 16,
   parameter int FRAC_BITS  = 16
) (
   input  logic                               clock,
   input  logic                               adv,
   input  logic signed [COORD_BITS-1:0]       sx [3],
   input  logic signed [COORD_BITS-1:0]       sy [3],
   input  logic signed [COORD_BITS-1:0]       dx [3],
   input  logic signed [COORD_BITS-1:0]       dy [3],
   output logic [2*COORD_BITS+2:0]            rem0 [6],
   output logic [aftp_pkg::QW-1:0]            low0 [6],
   output logic [2*COORD_BITS+2:0]            dmag,
   output aftp_pkg::aftp_flags_type           flags [6]
);
   localparam int C    = COORD_BITS;
   localparam int QW   = aftp_pkg::QW;
   localparam int CW1  = C + 1;
   localparam int P2W  = 2 * C;
   localparam int CW2  = 2 * C + 1;
   localparam int DW   = 2 * C + 3;
   localparam int PW1  = 2 * C + 1;
   localparam int PW2  = 3 * C + 1;
   localparam int NW   = 3 * C + 3;
   localparam int CMPW = NW + QW;
   localparam int XW   = NW + FRAC_BITS + DW + QW;

   logic signed [C-1:0]   sx_ff [3], sy_ff [3], dxa_ff [3], dya_ff [3];
   logic signed [C-1:0]   dxb_ff [3], dyb_ff [3];
   logic signed [CW1-1:0] c0_ff [3], c1_ff [3];
   logic signed [CW2-1:0] c2_ff [3];
   logic signed [CW1-1:0] c0_in [3], c1_in [3];
   logic signed [CW2-1:0] c2_in [3];
   logic signed [PW1-1:0] p0_ff [6], p1_ff [6];
   logic signed [PW2-1:0] p2_ff [6];
   logic signed [DW-1:0]  detc_ff, detd_ff;
   logic signed [NW-1:0]  num_ff [6];
   logic [DW-1:0]         rem_ff [6], dmag_ff;
   logic [QW-1:0]         low_ff [6];
   aftp_pkg::aftp_flags_type flg_ff [6];

   always_comb begin
      c0_in[0] = CW1'(sy_ff[1]) - CW1'(sy_ff[2]);
      c0_in[1] = CW1'(sy_ff[2]) - CW1'(sy_ff[0]);
      c0_in[2] = CW1'(sy_ff[0]) - CW1'(sy_ff[1]);
      c1_in[0] = CW1'(sx_ff[2]) - CW1'(sx_ff[1]);
      c1_in[1] = CW1'(sx_ff[0]) - CW1'(sx_ff[2]);
      c1_in[2] = CW1'(sx_ff[1]) - CW1'(sx_ff[0]);
      c2_in[0] = CW2'(P2W'(sx_ff[1]) * P2W'(sy_ff[2])) - CW2'(P2W'(sy_ff[1]) * P2W'(sx_ff[2]));
      c2_in[1] = CW2'(P2W'(sy_ff[0]) * P2W'(sx_ff[2])) - CW2'(P2W'(sx_ff[0]) * P2W'(sy_ff[2]));
      c2_in[2] = CW2'(P2W'(sx_ff[0]) * P2W'(sy_ff[1])) - CW2'(P2W'(sy_ff[0]) * P2W'(sx_ff[1]));
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            sx_ff[i]  <= sx[i];
            sy_ff[i]  <= sy[i];
            dxa_ff[i] <= dx[i];
            dya_ff[i] <= dy[i];
            c0_ff[i]  <= c0_in[i];
            c1_ff[i]  <= c1_in[i];
            c2_ff[i]  <= c2_in[i];
            dxb_ff[i] <= dxa_ff[i];
            dyb_ff[i] <= dya_ff[i];
            p0_ff[i]   <= PW1'(c0_ff[i]) * PW1'(dxb_ff[i]);
            p0_ff[i+3] <= PW1'(c0_ff[i]) * PW1'(dyb_ff[i]);
            p1_ff[i]   <= PW1'(c1_ff[i]) * PW1'(dxb_ff[i]);
            p1_ff[i+3] <= PW1'(c1_ff[i]) * PW1'(dyb_ff[i]);
            p2_ff[i]   <= PW2'(c2_ff[i]) * PW2'(dxb_ff[i]);
            p2_ff[i+3] <= PW2'(c2_ff[i]) * PW2'(dyb_ff[i]);
         end
         detc_ff <= DW'(c2_ff[0]) + DW'(c2_ff[1]) + DW'(c2_ff[2]);
         detd_ff <= detc_ff;
         num_ff[0] <= NW'(p0_ff[0]) + NW'(p0_ff[1]) + NW'(p0_ff[2]);
         num_ff[1] <= NW'(p0_ff[3]) + NW'(p0_ff[4]) + NW'(p0_ff[5]);
         num_ff[2] <= NW'(p1_ff[0]) + NW'(p1_ff[1]) + NW'(p1_ff[2]);
         num_ff[3] <= NW'(p1_ff[3]) + NW'(p1_ff[4]) + NW'(p1_ff[5]);
         num_ff[4] <= NW'(p2_ff[0]) + NW'(p2_ff[1]) + NW'(p2_ff[2]);
         num_ff[5] <= NW'(p2_ff[3]) + NW'(p2_ff[4]) + NW'(p2_ff[5]);
      end
   end

   logic [NW-1:0]   mag [6];
   logic [DW-1:0]   dm;
   logic [XW-1:0]   nx [6];
   logic            ovf [6];

   always_comb begin
      dm = detd_ff[DW-1] ? DW'(-detd_ff) : DW'(detd_ff);
      for (int k = 0; k < 6; k++) begin
         mag[k] = num_ff[k][NW-1] ? NW'(-num_ff[k]) : NW'(num_ff[k]);
         nx[k]  = XW'(mag[k]) << FRAC_BITS;
         ovf[k] = (CMPW'(mag[k]) >= (CMPW'(dm) << (QW - FRAC_BITS)));
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dmag_ff <= dm;
         for (int k = 0; k < 6; k++) begin
            rem_ff[k]          <= nx[k][QW +: DW];
            low_ff[k]          <= nx[k][0 +: QW];
            flg_ff[k].singular <= (detd_ff == '0);
            flg_ff[k].neg      <= num_ff[k][NW-1] ^ detd_ff[DW-1];
            flg_ff[k].ovf      <= ovf[k];
         end
      end
   end

   assign dmag = dmag_ff;
   assign rem0 = rem_ff;
   assign low0 = low_ff;
   assign flags = flg_ff;

endmodule

>>> src/aftp_div_cell.sv
// ---------------------------------------------------------------------------
// aftp_div_cell
// One restoring-division step: shift in a dividend bit, subtract if it fits.
// ---------------------------------------------------------------------------
module aftp_div_cell #(
   parameter int DW = 35
) (
   input  logic                           clock,
   input  logic                           adv,
   input  logic [DW-1:0]                  up_rem,
   input  logic [aftp_pkg::QW-1:0]        up_low,
   input  logic [aftp_pkg::QW-1:0]        up_quo,
   input  logic [DW-1:0]                  up_den,
   input  aftp_pkg::aftp_flags_type       up_flags,
   output logic [DW-1:0]                  dn_rem,
   output logic [aftp_pkg::QW-1:0]        dn_low,
   output logic [aftp_pkg::QW-1:0]        dn_quo,
   output logic [DW-1:0]                  dn_den,
   output aftp_pkg::aftp_flags_type       dn_flags
);
   localparam int QW = aftp_pkg::QW;

   logic [DW:0]   trial, diff;
   logic          fits;
   logic [DW-1:0] rem_ff, rem_in, den_ff;
   logic [QW-1:0] low_ff, quo_ff;
   aftp_pkg::aftp_flags_type flags_ff;

   always_comb begin
      trial  = {up_rem, up_low[QW-1]};
      diff   = trial - {1'b0, up_den};
      fits   = (trial >= {1'b0, up_den});
      rem_in = fits ? diff[DW-1:0] : trial[DW-1:0];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff   <= rem_in;
         low_ff   <= {up_low[QW-2:0], 1'b0};
         quo_ff   <= {up_quo[QW-2:0], fits};
         den_ff   <= up_den;
         flags_ff <= up_flags;
      end
   end

   assign dn_rem   = rem_ff;
   assign dn_low   = low_ff;
   assign dn_quo   = quo_ff;
   assign dn_den   = den_ff;
   assign dn_flags = flags_ff;

endmodule

>>> src/affine_from_three_point_pairs_core.sv
// ---------------------------------------------------------------------------
// affine_from_three_point_pairs_core
// Solves the affine map taking three source points onto three destination
// points; six Q16.16 coefficients, truncated and saturated, plus a singular flag.
//
//   channel  dir  handshake      payload
//   req_ch   in   valid/ready    src_a..c x/y, dst_a..c x/y
//   rsp_ch   out  valid/ready    coef_xx/xy/yx/yy, shift_x/y, singular
//
// One transaction per cycle while the pipeline advances; 5 setup stages, 32 divider
// cells and an output register. The whole pipeline advances when the output
// register is empty or being taken, so req ready follows rsp ready.
// Reset clears the valid bits only.
// ---------------------------------------------------------------------------
module affine_from_three_point_pairs_core #(
   parameter int COORD_BITS = 16,
   parameter int FRAC_BITS  = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   aftp_req_if.sink                 req_ch,
   aftp_rsp_if.source               rsp_ch
);
   localparam int QW    = aftp_pkg::QW;
   localparam int DW    = 2 * COORD_BITS + 3;
   localparam int NSTG  = 5 + QW;

   logic                        adv;
   logic [NSTG-1:0]             vld_ff, vld_in;
   logic                        rsp_valid_ff;
   logic signed [COORD_BITS-1:0] sx [3], sy [3], dx [3], dy [3];
   logic [DW-1:0]               rem0 [6];
   logic [QW-1:0]               low0 [6];
   logic [DW-1:0]               dmag;
   aftp_pkg::aftp_flags_type    flags0 [6];
   logic [QW-1:0]               res_quo [6];
   aftp_pkg::aftp_flags_type    res_flg [6];
   logic [QW-1:0]               coef_in [6];
   logic [QW-1:0]               coef_ff [6];
   logic                        sing_ff;

   assign adv          = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = adv;

   assign sx = '{req_ch.src_ax, req_ch.src_bx, req_ch.src_cx};
   assign sy = '{req_ch.src_ay, req_ch.src_by, req_ch.src_cy};
   assign dx = '{req_ch.dst_ax, req_ch.dst_bx, req_ch.dst_cx};
   assign dy = '{req_ch.dst_ay, req_ch.dst_by, req_ch.dst_cy};

   aftp_setup #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_setup (
      .clock (clock), .adv (adv),
      .sx (sx), .sy (sy), .dx (dx), .dy (dy),
      .rem0 (rem0), .low0 (low0), .dmag (dmag), .flags (flags0)
   );

   genvar ln, st;
   generate
      for (ln = 0; ln < 6; ln++) begin : g_lane
         logic [DW-1:0]            r [QW+1];
         logic [QW-1:0]            l [QW+1];
         logic [QW-1:0]            q [QW+1];
         logic [DW-1:0]            d [QW+1];
         aftp_pkg::aftp_flags_type f [QW+1];

         assign r[0] = rem0[ln];
         assign l[0] = low0[ln];
         assign q[0] = '0;
         assign d[0] = dmag;
         assign f[0] = flags0[ln];

         for (st = 0; st < QW; st++) begin : g_cell
            aftp_div_cell #(.DW(DW)) u_cell (
               .clock (clock), .adv (adv),
               .up_rem (r[st]), .up_low (l[st]), .up_quo (q[st]),
               .up_den (d[st]), .up_flags (f[st]),
               .dn_rem (r[st+1]), .dn_low (l[st+1]), .dn_quo (q[st+1]),
               .dn_den (d[st+1]), .dn_flags (f[st+1])
            );
         end

         assign res_quo[ln] = q[QW];
         assign res_flg[ln] = f[QW];
      end
   endgenerate

   always_comb begin
      for (int k = 0; k < 6; k++) begin
         if (res_flg[k].singular) begin
            coef_in[k] = '0;
         end else if (res_flg[k].ovf) begin
            coef_in[k] = res_flg[k].neg ? aftp_pkg::SAT_MIN : aftp_pkg::SAT_MAX;
         end else if (res_flg[k].neg) begin
            coef_in[k] = (res_quo[k] > aftp_pkg::SAT_MIN) ? aftp_pkg::SAT_MIN
                                                          : (~res_quo[k] + 1'b1);
         end else begin
            coef_in[k] = (res_quo[k] > aftp_pkg::SAT_MAX) ? aftp_pkg::SAT_MAX
                                                          : res_quo[k];
         end
      end
   end

   assign vld_in = {vld_ff[NSTG-2:0], req_ch.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff       <= vld_in;
         rsp_valid_ff <= vld_ff[NSTG-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         coef_ff <= coef_in;
         sing_ff <= res_flg[0].singular;
      end
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.coef_xx  = coef_ff[0];
   assign rsp_ch.coef_xy  = coef_ff[1];
   assign rsp_ch.coef_yx  = coef_ff[2];
   assign rsp_ch.coef_yy  = coef_ff[3];
   assign rsp_ch.shift_x  = coef_ff[4];
   assign rsp_ch.shift_y  = coef_ff[5];
   assign rsp_ch.singular = sing_ff;

endmodule

>>> src/aftp_checker.sv
// ---------------------------------------------------------------------------
// aftp_checker
// Port-level checks on the affine solver, bound to the top level.
// ---------------------------------------------------------------------------
module aftp_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic [aftp_pkg::QW-1:0]  coef_xx, coef_xy, coef_yx, coef_yy,
   input logic [aftp_pkg::QW-1:0]  shift_x, shift_y,
   input logic                     singular
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_singular_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && singular |-> (coef_xx == '0) && (coef_xy == '0) && (coef_yx == '0) &&
                                (coef_yy == '0) && (shift_x == '0) && (shift_y == '0))
      else $error("singular response with nonzero coefficients");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty output");

endmodule

bind affine_from_three_point_pairs_core aftp_checker u_aftp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .coef_xx   (rsp_ch.coef_xx),
   .coef_xy   (rsp_ch.coef_xy),
   .coef_yx   (rsp_ch.coef_yx),
   .coef_yy   (rsp_ch.coef_yy),
   .shift_x   (rsp_ch.shift_x),
   .shift_y   (rsp_ch.shift_y),
   .singular  (rsp_ch.singular)
);

>>> test/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Testbench for the three-point affine solver core.
// A queue-fed driver offers point sets with random gaps. A monitor takes the
// responses with random stalls and one long hold-off, and compares each one
// against a software solve of the same transaction.
// ---------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic signed [15:0] c[12];
   } point_set_type;

   typedef struct {
      logic signed [aftp_pkg::QW-1:0] v[6];
      logic                           singular;
   } affine_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count = 0;
   int   set_total = 0;
   int   sent_count = 0;
   int   taken_count = 0;
   bit   hold_done = 1'b0;

   point_set_type pending_sets[$];
   affine_type    expected_maps[$];
   point_set_type cur_set;

   aftp_req_if #(.COORD_BITS(16)) req_ch ();
   aftp_rsp_if                    rsp_ch ();

   affine_from_three_point_pairs_core #(.COORD_BITS(16), .FRAC_BITS(16)) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic affine_type solve_affine(point_set_type p);
      longint s[3][3];
      longint d[2][3];
      longint cof[3][3];
      longint det;
      longint mnr;
      int j, k, a, b;
      logic signed [127:0] num, t1, t2, wdet, q;
      affine_type r;
      for (int i = 0; i < 3; i++) begin
         s[i][0] = p.c[2*i];
         s[i][1] = p.c[2*i+1];
         s[i][2] = 1;
         d[0][i] = p.c[6+2*i];
         d[1][i] = p.c[7+2*i];
      end
      for (int i = 0; i < 3; i++) begin
         for (int cc = 0; cc < 3; cc++) begin
            j = (i == 0) ? 1 : 0;
            k = (i == 2) ? 1 : 2;
            a = (cc == 0) ? 1 : 0;
            b = (cc == 2) ? 1 : 2;
            mnr = s[j][a] * s[k][b] - s[j][b] * s[k][a];
            cof[i][cc] = ((i + cc) % 2 == 1) ? -mnr : mnr;
         end
      end
      det = cof[0][2] + cof[1][2] + cof[2][2];
      r.singular = (det == 0);
      for (int n = 0; n < 6; n++) r.v[n] = '0;
      if (det != 0) begin
         wdet = det;
         for (int rr = 0; rr < 3; rr++) begin
            for (int ax = 0; ax < 2; ax++) begin
               num = '0;
               for (int i = 0; i < 3; i++) begin
                  t1 = cof[i][rr];
                  t2 = d[ax][i];
                  num = num + t1 * t2;
               end
               num = num <<< 16;
               q = num / wdet;
               if (q > 128'sh7FFF_FFFF) r.v[2*rr+ax] = aftp_pkg::SAT_MAX;
               else if (q < -128'sh8000_0000) r.v[2*rr+ax] = aftp_pkg::SAT_MIN;
               else r.v[2*rr+ax] = q[31:0];
            end
         end
      end
      return r;
   endfunction

   function automatic point_set_type random_set();
      point_set_type p;
      int mode;
      int dx, dy, t, u;
      mode = $urandom_range(0, 9);
      for (int n = 0; n < 12; n++) begin
         if (mode < 3) p.c[n] = 16'($urandom);
         else p.c[n] = 16'($signed($urandom_range(0, 400)) - 200);
      end
      if (mode == 7 || mode == 8) begin
         // collinear source points
         dx = $signed($urandom_range(0, 40)) - 20;
         dy = $signed($urandom_range(0, 40)) - 20;
         t = $signed($urandom_range(0, 20)) - 10;
         u = $signed($urandom_range(0, 20)) - 10;
         p.c[2] = 16'(p.c[0] + t * dx);
         p.c[3] = 16'(p.c[1] + t * dy);
         p.c[4] = 16'(p.c[0] + u * dx);
         p.c[5] = 16'(p.c[1] + u * dy);
      end else if (mode == 9) begin
         // near-degenerate triangle, large destination
         p.c[2] = 16'(p.c[0] + 1);
         p.c[3] = p.c[1];
         p.c[4] = p.c[0];
         p.c[5] = 16'(p.c[1] + $signed($urandom_range(1, 2)));
         for (int n = 6; n < 12; n++) p.c[n] = 16'($urandom);
      end
      return p;
   endfunction

   function automatic point_set_type make_set(int v0, int v1, int v2, int v3, int v4,
                                              int v5, int v6, int v7, int v8, int v9,
                                              int v10, int v11);
      point_set_type p;
      p.c[0] = 16'(v0); p.c[1] = 16'(v1); p.c[2] = 16'(v2); p.c[3] = 16'(v3);
      p.c[4] = 16'(v4); p.c[5] = 16'(v5); p.c[6] = 16'(v6); p.c[7] = 16'(v7);
      p.c[8] = 16'(v8); p.c[9] = 16'(v9); p.c[10] = 16'(v10); p.c[11] = 16'(v11);
      return p;
   endfunction

   initial begin
      pending_sets.push_back(make_set(0, 0, 1, 0, 0, 1, 0, 0, 1, 0, 0, 1));
      pending_sets.push_back(make_set(0, 0, 1, 0, 0, 1, 5, 7, 8, 9, -3, 4));
      pending_sets.push_back(make_set(0, 0, 0, 0, 0, 0, 1, 2, 3, 4, 5, 6));
      pending_sets.push_back(make_set(1, 1, 2, 2, 3, 3, 9, 9, 9, 9, 9, 9));
      pending_sets.push_back(make_set(-32768, -32768, -32768, -32768, -32768, -32768,
                                      -32768, -32768, -32768, -32768, -32768, -32768));
      pending_sets.push_back(make_set(32767, 32767, 32767, 32767, 32767, 32767,
                                      32767, 32767, 32767, 32767, 32767, 32767));
      pending_sets.push_back(make_set(0, 0, 1, 0, 0, 1, 32767, 32767, -32768, 0, 0, -32768));
      pending_sets.push_back(make_set(0, 0, 1, 0, 0, 1, -32768, -32768, 32767, 0, 0, 32767));
      pending_sets.push_back(make_set(-32768, -32768, 32767, -32768, -32768, 32767,
                                      32767, -32768, -32768, 32767, 0, 0));
      pending_sets.push_back(make_set(-32768, 32767, 32767, -32768, 0, 0,
                                      -32768, 32767, 32767, -32768, 1, -1));
      pending_sets.push_back(make_set(0, 0, 32767, 1, 32766, 1, 32767, 0, -32768, 0, 5, 5));
      pending_sets.push_back(make_set(3, -7, 3, 9, 3, 100, 1, 2, 3, 4, 5, 6));
      pending_sets.push_back(make_set(10, 20, 30, 40, 11, 25, -100, 50, 70, -20, 3, 3));
      pending_sets.push_back(make_set(0, 0, 3, 0, 0, 7, 1, 1, 2, 2, -1, -1));
      pending_sets.push_back(make_set(-1, -1, -1, -1, -1, -1, 0, 0, 0, 0, 0, 0));
      pending_sets.push_back(make_set(0, 0, 2, 0, 0, 2, 1, 0, -1, 0, 0, -1));
      for (int n = 0; n < 1750; n++) pending_sets.push_back(random_set());
      set_total = pending_sets.size();
   end

   // driver
   int driver_gap = 0;
   always @(posedge clock) begin
      logic next_valid;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            expected_maps.push_back(solve_affine(cur_set));
            sent_count++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            next_valid = 1'b0;
            if (driver_gap > 0) begin
               driver_gap--;
            end else if (pending_sets.size() > 0) begin
               if (sent_count < set_total - 150 && $urandom_range(0, 7) == 0) begin
                  driver_gap = $urandom_range(1, 14);
               end else begin
                  cur_set = pending_sets.pop_front();
                  next_valid = 1'b1;
                  req_ch.src_ax <= cur_set.c[0];
                  req_ch.src_ay <= cur_set.c[1];
                  req_ch.src_bx <= cur_set.c[2];
                  req_ch.src_by <= cur_set.c[3];
                  req_ch.src_cx <= cur_set.c[4];
                  req_ch.src_cy <= cur_set.c[5];
                  req_ch.dst_ax <= cur_set.c[6];
                  req_ch.dst_ay <= cur_set.c[7];
                  req_ch.dst_bx <= cur_set.c[8];
                  req_ch.dst_by <= cur_set.c[9];
                  req_ch.dst_cx <= cur_set.c[10];
                  req_ch.dst_cy <= cur_set.c[11];
               end
            end
            req_ch.valid <= next_valid;
         end
      end
   end

   initial begin
      req_ch.valid = 1'b0;
      {req_ch.src_ax, req_ch.src_ay, req_ch.src_bx, req_ch.src_by} = '0;
      {req_ch.src_cx, req_ch.src_cy, req_ch.dst_ax, req_ch.dst_ay} = '0;
      {req_ch.dst_bx, req_ch.dst_by, req_ch.dst_cx, req_ch.dst_cy} = '0;
      rsp_ch.ready = 1'b0;
   end

   // receiver back-pressure
   int stall_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ch.ready <= (stall_left == 0);
      end else if (!hold_done && taken_count >= 400) begin
         hold_done = 1'b1;
         stall_left = 300;
         rsp_ch.ready <= 1'b0;
      end else if (taken_count < set_total - 150 && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(1, 14);
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // monitor
   always @(posedge clock) begin
      affine_type want;
      logic signed [aftp_pkg::QW-1:0] got[6];
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         taken_count++;
         got[0] = rsp_ch.coef_xx; got[1] = rsp_ch.coef_xy;
         got[2] = rsp_ch.coef_yx; got[3] = rsp_ch.coef_yy;
         got[4] = rsp_ch.shift_x; got[5] = rsp_ch.shift_y;
         if (expected_maps.size() == 0) begin
            fail_count++;
            $display("%0t: unexpected transaction, coef_xx %h", $time, got[0]);
         end else begin
            want = expected_maps.pop_front();
            for (int n = 0; n < 6; n++) begin
               if (got[n] !== want.v[n]) begin
                  fail_count++;
                  $display("%0t: coefficient %0d expected %h actual %h",
                           $time, n, want.v[n], got[n]);
               end
            end
            if (rsp_ch.singular !== want.singular) begin
               fail_count++;
               $display("%0t: singular expected %b actual %b",
                        $time, want.singular, rsp_ch.singular);
            end
         end
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      wait (set_total > 0 && sent_count == set_total && expected_maps.size() == 0);
      repeat (60) @(posedge clock);
      if (fail_count == 0 && expected_maps.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #(12 * 400000);
      $display("CHECK FAILED");
      $finish;
   end

endmodule
